@@ src/lcrs_pkg.sv @@
// Shared types and codes for the link connect and retry supervisor.
`timescale 1ns / 1ps

package lcrs_pkg;

	// Supervisor states, as reported on link_state.
	typedef enum logic [1:0] {
		ST_OFF        = 2'd0,
		ST_CONNECTING = 2'd1,
		ST_CONNECTED  = 2'd2,
		ST_FAILED     = 2'd3
	} state_t;

	// Commands issued to the radio.
	typedef enum logic [1:0] {
		CMD_NONE       = 2'd0,
		CMD_POWER_OFF  = 2'd1,
		CMD_START      = 2'd2,
		CMD_DISCONNECT = 2'd3
	} cmd_t;

	// Status codes reported by the radio.
	typedef enum logic [1:0] {
		LS_OTHER     = 2'd0,
		LS_CONNECTED = 2'd1,
		LS_FAILED    = 2'd2,
		LS_NO_NET    = 2'd3
	} link_status_t;

	// Configuration register indexes.
	localparam int unsigned CfgIndexWidth = 3;
	localparam logic [CfgIndexWidth-1:0] REG_CREDENTIALS_VALID   = 3'd0;
	localparam logic [CfgIndexWidth-1:0] REG_RETRY_DELAY_MS      = 3'd1;
	localparam logic [CfgIndexWidth-1:0] REG_CONNECT_TIMEOUT_MS  = 3'd2;
	localparam logic [CfgIndexWidth-1:0] REG_NO_NETWORK_GRACE_MS = 3'd3;

	// One tick word as it travels into the supervisor core.
	typedef struct packed {
		logic [31:0]  now_ms;
		logic         requested;
		link_status_t link_status;
		logic [31:0]  local_ip;
	} tick_t;

	// Configuration register contents.
	typedef struct packed {
		logic        credentials_valid;
		logic [31:0] retry_delay_ms;
		logic [31:0] connect_timeout_ms;
		logic [31:0] no_network_grace_ms;
	} cfg_t;

	// One result word from the supervisor core.
	typedef struct packed {
		state_t      link_state;
		logic [31:0] ip_addr;
		cmd_t        radio_cmd;
	} result_t;

endpackage

@@ src/link_connect_retry_supervisor.sv @@
// Top level of the link connect and retry supervisor: ports, configuration and pipeline.
`timescale 1ns / 1ps

// Each tick word gives the time, the request, the radio status and the local address,
// and produces exactly one result word: the state after the tick, the latched address
// (zero unless connected) and a radio command. A word passes through an input register
// and then a result register before its result appears on the outputs, and a new word
// is taken in every cycle while the result side keeps up. The throughput of one word per
// cycle is set by the state update in the core, whose next state feeds the following
// word directly. Configuration is written through a plain write port with no read-back;
// writes to indexes beyond the register list are ignored.

module link_connect_retry_supervisor (
	input  logic        clk,
	input  logic        arst_n,
	// Configuration write port.
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_wdata,
	// Tick input channel.
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] now_ms,
	input  logic        requested,
	input  logic [1:0]  link_status,
	input  logic [31:0] local_ip,
	// Result channel.
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  link_state,
	output logic [31:0] ip_addr,
	output logic [1:0]  radio_cmd
);

	lcrs_pkg::cfg_t    cfg_q;
	lcrs_pkg::tick_t   tick_s1;
	logic              valid_s1;
	lcrs_pkg::result_t core_result;
	lcrs_pkg::result_t result_s2;
	logic              valid_s2;
	logic              advance;
	logic              in_accept;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				lcrs_pkg::REG_CREDENTIALS_VALID:   cfg_q.credentials_valid   <= cfg_wdata[0];
				lcrs_pkg::REG_RETRY_DELAY_MS:      cfg_q.retry_delay_ms      <= cfg_wdata;
				lcrs_pkg::REG_CONNECT_TIMEOUT_MS:  cfg_q.connect_timeout_ms  <= cfg_wdata;
				lcrs_pkg::REG_NO_NETWORK_GRACE_MS: cfg_q.no_network_grace_ms <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	// Handshake: the held word moves on whenever the result register is free or draining.
	assign advance   = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall  = valid_s1 && !advance;
	assign in_accept = in_valid && !in_stall;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			tick_s1.now_ms      <= now_ms;
			tick_s1.requested   <= requested;
			tick_s1.link_status <= lcrs_pkg::link_status_t'(link_status);
			tick_s1.local_ip    <= local_ip;
		end
	end

	// Supervisor core: state update for the held word.
	lcrs_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.tick   (tick_s1),
		.cfg    (cfg_q),
		.result (core_result)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= core_result;
		end
	end

	assign out_valid  = valid_s2;
	assign link_state = result_s2.link_state;
	assign ip_addr    = result_s2.ip_addr;
	assign radio_cmd  = result_s2.radio_cmd;

	// The address is only shown in the connected state.
	a_ip_only_connected: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (result_s2.link_state == lcrs_pkg::ST_CONNECTED ||
			result_s2.ip_addr == 32'd0))
		else $error("address shown outside the connected state");

	// A start command always leaves the block connecting.
	a_start_connecting: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && result_s2.radio_cmd == lcrs_pkg::CMD_START) |->
			result_s2.link_state == lcrs_pkg::ST_CONNECTING)
		else $error("start command without connecting state");

	// A disconnect always leaves the block failed, a power-off always leaves it off.
	a_cmd_state: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((result_s2.radio_cmd != lcrs_pkg::CMD_DISCONNECT ||
			result_s2.link_state == lcrs_pkg::ST_FAILED) &&
			(result_s2.radio_cmd != lcrs_pkg::CMD_POWER_OFF ||
			result_s2.link_state == lcrs_pkg::ST_OFF)))
		else $error("command does not match resulting state");

	// A word that cannot move on is held.
	a_word_held: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> valid_s1)
		else $error("held input word lost");

endmodule

@@ src/lcrs_core.sv @@
// Supervisor state registers and the next-state logic for one tick word.
`timescale 1ns / 1ps

module lcrs_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  lcrs_pkg::tick_t   tick,
	input  lcrs_pkg::cfg_t    cfg,
	output lcrs_pkg::result_t result
);

	lcrs_pkg::state_t state_q, state_d;
	logic [31:0] deadline_q, deadline_d;
	logic [31:0] start_q, start_d;
	logic [31:0] held_ip_q, held_ip_d;
	logic        off_done_q, off_done_d;
	lcrs_pkg::cmd_t cmd;

	logic [31:0] armed;
	logic [31:0] retry_diff;
	logic [31:0] elapsed;
	logic [31:0] fail_deadline;

	// Shared arithmetic for the retry timer and the attempt timer.
	assign fail_deadline = tick.now_ms + cfg.retry_delay_ms;
	assign armed         = (deadline_q == 32'd0) ? fail_deadline : deadline_q;
	assign retry_diff    = tick.now_ms - armed;
	assign elapsed       = tick.now_ms - start_q;

	// Next state and command for the word in hand.
	always_comb begin
		state_d    = state_q;
		deadline_d = deadline_q;
		start_d    = start_q;
		held_ip_d  = held_ip_q;
		off_done_d = off_done_q;
		cmd        = lcrs_pkg::CMD_NONE;
		if (!tick.requested) begin
			deadline_d = 32'd0;
			if (state_q != lcrs_pkg::ST_OFF || !off_done_q) begin
				held_ip_d  = 32'd0;
				state_d    = lcrs_pkg::ST_OFF;
				off_done_d = 1'b1;
				cmd        = lcrs_pkg::CMD_POWER_OFF;
			end
		end else if (!cfg.credentials_valid) begin
			state_d = lcrs_pkg::ST_FAILED;
		end else begin
			case (state_q)
				lcrs_pkg::ST_OFF: begin
					held_ip_d  = 32'd0;
					start_d    = tick.now_ms;
					off_done_d = 1'b0;
					state_d    = lcrs_pkg::ST_CONNECTING;
					cmd        = lcrs_pkg::CMD_START;
				end
				lcrs_pkg::ST_FAILED: begin
					// The deadline is compared as a wrapping signed difference.
					if (!retry_diff[31]) begin
						deadline_d = 32'd0;
						held_ip_d  = 32'd0;
						start_d    = tick.now_ms;
						off_done_d = 1'b0;
						state_d    = lcrs_pkg::ST_CONNECTING;
						cmd        = lcrs_pkg::CMD_START;
					end else begin
						deadline_d = armed;
					end
				end
				lcrs_pkg::ST_CONNECTING: begin
					if (tick.link_status == lcrs_pkg::LS_CONNECTED) begin
						held_ip_d = tick.local_ip;
						state_d   = lcrs_pkg::ST_CONNECTED;
					end else if (tick.link_status == lcrs_pkg::LS_FAILED ||
							(tick.link_status == lcrs_pkg::LS_NO_NET &&
							elapsed >= cfg.no_network_grace_ms) ||
							elapsed >= cfg.connect_timeout_ms) begin
						state_d    = lcrs_pkg::ST_FAILED;
						deadline_d = fail_deadline;
						cmd        = lcrs_pkg::CMD_DISCONNECT;
					end
				end
				lcrs_pkg::ST_CONNECTED: begin
					if (tick.link_status != lcrs_pkg::LS_CONNECTED) begin
						held_ip_d  = 32'd0;
						state_d    = lcrs_pkg::ST_FAILED;
						deadline_d = fail_deadline;
						cmd        = lcrs_pkg::CMD_DISCONNECT;
					end
				end
				default: begin
					state_d = lcrs_pkg::ST_OFF;
				end
			endcase
		end
	end

	// The address is shown only while connected.
	always_comb begin
		result.link_state = state_d;
		result.ip_addr    = (state_d == lcrs_pkg::ST_CONNECTED) ? held_ip_d : 32'd0;
		result.radio_cmd  = cmd;
	end

	// State advances once for every word that passes through.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= lcrs_pkg::ST_OFF;
			deadline_q <= 32'd0;
			start_q    <= 32'd0;
			held_ip_q  <= 32'd0;
			off_done_q <= 1'b0;
		end else if (step) begin
			state_q    <= state_d;
			deadline_q <= deadline_d;
			start_q    <= start_d;
			held_ip_q  <= held_ip_d;
			off_done_q <= off_done_d;
		end
	end

endmodule
